### hw/rtl/assert_macros.svh
// Assertion macros shared by the flow-updating averaging RTL.
// Needs a clock named clock and a reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define FUA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another one in the following cycle.
`define FUA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/fua_pkg.sv
`timescale 1ns / 1ps
// Package for the flow-updating averaging node: codes, entry layout, sequencer states.
// No dependencies.
package fua_pkg;

   localparam int NEIGH_MAX_DEF = 16;
   localparam int NUM_W = 64;
   localparam int ID_W  = 64;

   typedef enum logic [2:0] {
      CMD_UP    = 3'd0,
      CMD_DOWN  = 3'd1,
      CMD_HDR   = 3'd2,
      CMD_PAIR  = 3'd3,
      CMD_TICK  = 3'd4,
      CMD_SET   = 3'd5,
      CMD_READ  = 3'd6,
      CMD_CLEAR = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_EST    = 2'd0,
      KIND_FLOW   = 2'd1,
      KIND_READ   = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CK,
      S_UPDATE,
      S_PAIR_RD,
      S_PAIR_WR,
      S_SUM_RD,
      S_SUM_CK,
      S_DIV_GO,
      S_DIV_WAIT,
      S_EST,
      S_FLOW_RD,
      S_FLOW_CK,
      S_READ
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id_high;
      logic [ID_W-1:0]  id_low;
      logic [NUM_W-1:0] flow;
      logic [NUM_W-1:0] estimate;
   } entry_type;

endpackage

### hw/rtl/fua_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fua_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/fua_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider for unsigned operands, one quotient bit a cycle.
// No dependencies.
module fua_div #(
   parameter int DIVIDEND_W = 71,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = !diff[DIVISOR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], ge};
         rem_ff <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hw/rtl/flow_updating_average_node.sv
`timescale 1ns / 1ps
// Flow-updating averaging node. Up/down/header scan the table, reading and then comparing
// each entry in turn until a hit (N = NEIGH_MAX); pair reads and rewrites the sender's entry.
// Tick: sum the table, then divide with the divider (AW = 66+clog2(N+1), 71 for N=16),
// then walk the table again, skipping free entries and reading and updating used ones.
// One item in work at a time; the table RAM's single read port sets the pace.
// Reset (synchronous, high) empties the table and clears value, estimate and id regs.
`include "assert_macros.svh"
module flow_updating_average_node import fua_pkg::*; #(
   parameter int NEIGH_MAX = NEIGH_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_command,
   input  logic [ID_W-1:0]   req_node_id_high,
   input  logic [ID_W-1:0]   req_node_id_low,
   input  logic [NUM_W-1:0]  req_number_in,
   // result items
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [ID_W-1:0]   rsp_peer_id_high,
   output logic [ID_W-1:0]   rsp_peer_id_low,
   output logic [NUM_W-1:0]  rsp_first_number,
   output logic [NUM_W-1:0]  rsp_second_number,
   output logic [1:0]        rsp_status,
   output logic              rsp_last,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [63:0]       pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   localparam int IW      = (NEIGH_MAX > 1) ? $clog2(NEIGH_MAX) : 1;
   localparam int CW      = $clog2(NEIGH_MAX + 1);
   localparam int DW      = $clog2(NEIGH_MAX + 2);
   localparam int AW      = 66 + $clog2(NEIGH_MAX + 1);
   localparam int ENTRY_W = $bits(entry_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(NEIGH_MAX - 1);
   localparam logic [NUM_W-1:0] NUM_MIN = {1'b1, {(NUM_W-1){1'b0}}};
   localparam logic [NUM_W-1:0] NUM_MAX = {1'b0, {(NUM_W-1){1'b1}}};

   // sign-extend a Q32.32 value to the accumulator width
   function automatic logic [AW-1:0] sext(input logic [NUM_W-1:0] v);
      return {{(AW-NUM_W){v[NUM_W-1]}}, v};
   endfunction

   // clamp a wide signed value to Q32.32
   function automatic logic [NUM_W-1:0] sat(input logic [AW-1:0] v);
      logic [AW-NUM_W:0] top;
      top = v[AW-1:NUM_W-1];
      if ((&top) || !(|top)) begin
         return v[NUM_W-1:0];
      end
      return v[AW-1] ? NUM_MIN : NUM_MAX;
   endfunction

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ID_W-1:0]      id_hi_ff, id_hi_in;
   logic [ID_W-1:0]      id_lo_ff, id_lo_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic                 free_found_ff, free_found_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic [NUM_W-1:0]     found_flow_ff, found_flow_in;
   logic [NEIGH_MAX-1:0] valid_ff, valid_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [NUM_W-1:0]     local_ff, local_in;
   logic [NUM_W-1:0]     own_ff, own_in;
   logic [IW-1:0]        sender_slot_ff, sender_slot_in;
   logic                 sender_known_ff, sender_known_in;
   logic                 flow_taken_ff, flow_taken_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   logic [63:0]          my_id_high_ff, my_id_low_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             rsp_kind_ff;
   logic [ID_W-1:0]      rsp_idh_ff, rsp_idl_ff;
   logic [NUM_W-1:0]     rsp_n1_ff, rsp_n2_ff;
   status_type           rsp_status_ff;
   logic                 rsp_last_ff;

   // result staged for the output register
   logic                 out_load;
   logic                 out_free;
   kind_type             o_kind;
   logic [ID_W-1:0]      o_idh, o_idl;
   logic [NUM_W-1:0]     o_n1, o_n2;
   status_type           o_status;
   logic                 o_last;

   // table RAM and divider hookup
   logic                 ram_we;
   logic [IW-1:0]        ram_waddr, ram_raddr;
   entry_type            ram_wentry;
   logic [ENTRY_W-1:0]   ram_rdata;
   entry_type            rd_entry;
   logic                 div_start, div_done;
   logic [AW-1:0]        div_quo, div_dividend, quo_signed;
   logic [DW-1:0]        div_divisor;

   logic                 pair_ok;
   logic                 hit;
   logic                 higher;
   logic [NUM_W-1:0]     next_flow;

   assign rd_entry = entry_type'(ram_rdata);

   fua_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NEIGH_MAX)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ENTRY_W'(ram_wentry)),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // magnitude goes in, sign is restored on the way out
   assign div_dividend = acc_ff[AW-1] ? (~acc_ff + AW'(1)) : acc_ff;
   assign div_divisor  = DW'(count_ff) + DW'(1);
   assign quo_signed   = neg_ff ? (~div_quo + AW'(1)) : div_quo;

   fua_div #(
      .DIVIDEND_W (AW),
      .DIVISOR_W  (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------
   // Register port: my_id_high at 0, my_id_low at 8
   // ---------------------------------------------------------------
   assign pready = 1'b1;
   assign prdata = paddr[3] ? my_id_low_ff : my_id_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_high_ff <= '0;
         my_id_low_ff  <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr[3]) begin
            my_id_low_ff <= pwdata;
         end else begin
            my_id_high_ff <= pwdata;
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // a pair counts only for a live sender, once, and only when it names this node
   assign pair_ok = sender_known_ff && !flow_taken_ff && valid_ff[sender_slot_ff] &&
                    (req_node_id_high == my_id_high_ff) && (req_node_id_low == my_id_low_ff);

   assign hit = valid_ff[idx_ff] && (rd_entry.id_high == id_hi_ff) &&
                (rd_entry.id_low == id_lo_ff);

   // any used slot past the current one decides the last marker
   always_comb begin
      higher = 1'b0;
      for (int j = 0; j < NEIGH_MAX; j++) begin
         if (valid_ff[j] && (j > int'(idx_ff))) begin
            higher = 1'b1;
         end
      end
   end

   assign next_flow = sat(sext(rd_entry.flow) + sext(own_ff) - sext(rd_entry.estimate));

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      id_hi_in        = id_hi_ff;
      id_lo_in        = id_lo_ff;
      num_in          = num_ff;
      idx_in          = idx_ff;
      found_in        = found_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      found_flow_in   = found_flow_ff;
      valid_in        = valid_ff;
      count_in        = count_ff;
      local_in        = local_ff;
      own_in          = own_ff;
      sender_slot_in  = sender_slot_ff;
      sender_known_in = sender_known_ff;
      flow_taken_in   = flow_taken_ff;
      acc_in          = acc_ff;
      neg_in          = neg_ff;
      ram_we          = 1'b0;
      ram_waddr       = idx_ff;
      ram_raddr       = idx_ff;
      ram_wentry      = '0;
      div_start       = 1'b0;
      out_load        = 1'b0;
      o_kind          = KIND_STATUS;
      o_idh           = '0;
      o_idl           = '0;
      o_n1            = '0;
      o_n2            = '0;
      o_status        = STS_OK;
      o_last          = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = cmd_type'(req_command);
               id_hi_in      = req_node_id_high;
               id_lo_in      = req_node_id_low;
               num_in        = req_number_in;
               idx_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               unique case (cmd_type'(req_command))
                  CMD_UP, CMD_DOWN, CMD_HDR: begin
                     state_in = S_SCAN_RD;
                  end
                  CMD_PAIR: begin
                     if (pair_ok) begin
                        idx_in   = sender_slot_ff;
                        state_in = S_PAIR_RD;
                     end
                  end
                  CMD_TICK: begin
                     acc_in   = sext(local_ff);
                     state_in = S_SUM_RD;
                  end
                  CMD_SET: begin
                     local_in = req_number_in;
                  end
                  CMD_READ: begin
                     state_in = S_READ;
                  end
                  CMD_CLEAR: begin
                     // empty the table, keep value and estimate
                     valid_in        = '0;
                     count_in        = '0;
                     sender_slot_in  = '0;
                     sender_known_in = 1'b0;
                     flow_taken_in   = 1'b0;
                  end
               endcase
            end
         end

         // search the table for the id, note the lowest free slot on the way
         S_SCAN_RD: begin
            state_in = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            if (hit) begin
               found_in      = 1'b1;
               found_flow_in = rd_entry.flow;
            end
            if (!valid_ff[idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (hit || (idx_ff == LAST_IDX)) begin
               state_in = S_UPDATE;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_SCAN_RD;
            end
         end

         // apply the command and report its status; idx holds the hit slot
         S_UPDATE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               unique case (cmd_ff)
                  CMD_UP: begin
                     if (!found_ff) begin
                        if (free_found_ff) begin
                           ram_we                  = 1'b1;
                           ram_waddr               = free_idx_ff;
                           ram_wentry.id_high      = id_hi_ff;
                           ram_wentry.id_low       = id_lo_ff;
                           valid_in[free_idx_ff]   = 1'b1;
                           count_in                = count_ff + CW'(1);
                        end else begin
                           o_status = STS_FULL;
                        end
                     end
                  end
                  CMD_DOWN: begin
                     if (found_ff) begin
                        valid_in[idx_ff] = 1'b0;
                        count_in         = count_ff - CW'(1);
                        if (sender_known_ff && (sender_slot_ff == idx_ff)) begin
                           sender_known_in = 1'b0;
                           flow_taken_in   = 1'b0;
                        end
                     end else begin
                        o_status = STS_NOT_FOUND;
                     end
                  end
                  CMD_HDR: begin
                     flow_taken_in = 1'b0;
                     if (found_ff) begin
                        ram_we              = 1'b1;
                        ram_wentry.id_high  = id_hi_ff;
                        ram_wentry.id_low   = id_lo_ff;
                        ram_wentry.flow     = found_flow_ff;
                        ram_wentry.estimate = num_ff;
                        sender_slot_in      = idx_ff;
                        sender_known_in     = 1'b1;
                     end else if (free_found_ff) begin
                        ram_we                = 1'b1;
                        ram_waddr             = free_idx_ff;
                        ram_wentry.id_high    = id_hi_ff;
                        ram_wentry.id_low     = id_lo_ff;
                        ram_wentry.estimate   = num_ff;
                        valid_in[free_idx_ff] = 1'b1;
                        count_in              = count_ff + CW'(1);
                        sender_slot_in        = free_idx_ff;
                        sender_known_in       = 1'b1;
                     end else begin
                        sender_known_in = 1'b0;
                        o_status        = STS_FULL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // read-modify-write of the sender's flow
         S_PAIR_RD: begin
            state_in = S_PAIR_WR;
         end
         S_PAIR_WR: begin
            ram_we              = 1'b1;
            ram_wentry          = rd_entry;
            ram_wentry.flow     = (num_ff == NUM_MIN) ? NUM_MAX : (~num_ff + NUM_W'(1));
            flow_taken_in       = 1'b1;
            state_in            = S_IDLE;
         end

         // first walk: accumulate estimates minus flows
         S_SUM_RD: begin
            state_in = S_SUM_CK;
         end
         S_SUM_CK: begin
            if (valid_ff[idx_ff]) begin
               acc_in = acc_ff + sext(rd_entry.estimate) - sext(rd_entry.flow);
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_DIV_GO;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_SUM_RD;
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            neg_in    = acc_ff[AW-1];
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               own_in   = sat(quo_signed);
               state_in = S_EST;
            end
         end
         S_EST: begin
            if (out_free) begin
               out_load = 1'b1;
               o_kind   = KIND_EST;
               o_n1     = own_ff;
               o_last   = !(|valid_ff);
               idx_in   = '0;
               state_in = (|valid_ff) ? S_FLOW_RD : S_IDLE;
            end
         end

         // second walk: update each used entry and report it
         S_FLOW_RD: begin
            if (valid_ff[idx_ff]) begin
               state_in = S_FLOW_CK;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_FLOW_CK: begin
            if (out_free) begin
               ram_we              = 1'b1;
               ram_wentry          = rd_entry;
               ram_wentry.flow     = next_flow;
               ram_wentry.estimate = own_ff;
               out_load            = 1'b1;
               o_kind              = KIND_FLOW;
               o_idh               = rd_entry.id_high;
               o_idl               = rd_entry.id_low;
               o_n1                = next_flow;
               o_last              = !higher;
               if (!higher || (idx_ff == LAST_IDX)) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_FLOW_RD;
               end
            end
         end

         S_READ: begin
            if (out_free) begin
               out_load = 1'b1;
               o_kind   = KIND_READ;
               o_n1     = local_ff;
               o_n2     = own_ff;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // hold a result until taken, load a new one when the slot frees
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         valid_ff        <= '0;
         count_ff        <= '0;
         local_ff        <= '0;
         own_ff          <= '0;
         sender_slot_ff  <= '0;
         sender_known_ff <= 1'b0;
         flow_taken_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         count_ff        <= count_in;
         local_ff        <= local_in;
         own_ff          <= own_in;
         sender_slot_ff  <= sender_slot_in;
         sender_known_ff <= sender_known_in;
         flow_taken_ff   <= flow_taken_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_hi_ff      <= id_hi_in;
      id_lo_ff      <= id_lo_in;
      num_ff        <= num_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      found_flow_ff <= found_flow_in;
      acc_ff        <= acc_in;
      neg_ff        <= neg_in;
      if (out_load) begin
         rsp_kind_ff   <= o_kind;
         rsp_idh_ff    <= o_idh;
         rsp_idl_ff    <= o_idl;
         rsp_n1_ff     <= o_n1;
         rsp_n2_ff     <= o_n2;
         rsp_status_ff <= o_status;
         rsp_last_ff   <= o_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_peer_id_high  = rsp_idh_ff;
   assign rsp_peer_id_low   = rsp_idl_ff;
   assign rsp_first_number  = rsp_n1_ff;
   assign rsp_second_number = rsp_n2_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   `FUA_ASSERT(a_count_matches, count_ff == CW'($countones(valid_ff)), "neighbor count off")
   `FUA_ASSERT(a_sender_live, !sender_known_ff || valid_ff[sender_slot_ff], "stale sender")
   `FUA_ASSERT(a_taken_has_sender, !flow_taken_ff || sender_known_ff, "flow taken w/o sender")
   `FUA_ASSERT_NEXT(a_div_waits, div_start, state_ff == S_DIV_WAIT, "divider start lost")

endmodule

### verif/flow_updating_average_node_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for flow_updating_average_node: directed and random command items
// with an in-bench predictor of the neighbor table and Q32.32 averaging arithmetic.
// Depends on fua_pkg and the flow_updating_average_node RTL.
module flow_updating_average_node_tb;
   import fua_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int SETTLE_CYCLES = 400;   // covers the longest tick walk after the last result
   localparam logic signed [127:0] Q_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] Q_MIN = -Q_MAX - 1;
   localparam logic [3:0] ADDR_ID_HIGH = 4'd0;
   localparam logic [3:0] ADDR_ID_LOW  = 4'd8;

   typedef struct {
      kind_type   kind;
      logic [63:0] peer_high;
      logic [63:0] peer_low;
      logic [63:0] first_num;
      logic [63:0] second_num;
      status_type status;
      logic        last;
   } node_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_command = '0;
   logic [63:0] req_node_id_high = '0, req_node_id_low = '0, req_number_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind, rsp_status;
   logic [63:0] rsp_peer_id_high, rsp_peer_id_low, rsp_first_number, rsp_second_number;
   logic rsp_last;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic pready;

   flow_updating_average_node u_top (.*);

   always #5 clock = ~clock;

   // Predicted node state
   logic               nb_used [TABLE_DEPTH];
   logic [63:0]        nb_id_high [TABLE_DEPTH];
   logic [63:0]        nb_id_low [TABLE_DEPTH];
   logic signed [63:0] nb_flow [TABLE_DEPTH];
   logic signed [63:0] nb_estimate [TABLE_DEPTH];
   int                 nb_count;
   logic signed [63:0] local_val, own_est;
   int                 sender_idx;
   bit                 sender_valid, pair_taken;
   logic [63:0]        self_id_high, self_id_low;

   node_result_t expected_results[$];
   int  mismatch_count = 0;
   bit  allow_idle = 1'b1;
   logic [63:0] id_pool [24];

   function automatic logic signed [63:0] saturate_q(logic signed [127:0] x);
      if (x > Q_MAX) return Q_MAX[63:0];
      if (x < Q_MIN) return Q_MIN[63:0];
      return x[63:0];
   endfunction

   function automatic void expect_result(kind_type k, logic [63:0] ph, logic [63:0] pl,
                                         logic [63:0] n1, logic [63:0] n2,
                                         status_type st, logic lst);
      node_result_t r;
      r.kind = k; r.peer_high = ph; r.peer_low = pl;
      r.first_num = n1; r.second_num = n2; r.status = st; r.last = lst;
      expected_results.push_back(r);
   endfunction

   function automatic int find_neighbor(logic [63:0] h, logic [63:0] l);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (nb_used[i] && nb_id_high[i] == h && nb_id_low[i] == l) return i;
      return -1;
   endfunction

   function automatic int add_neighbor(logic [63:0] h, logic [63:0] l, logic [63:0] est);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!nb_used[i]) begin
            nb_used[i] = 1'b1; nb_id_high[i] = h; nb_id_low[i] = l;
            nb_flow[i] = '0; nb_estimate[i] = est; nb_count++;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void empty_table();
      for (int i = 0; i < TABLE_DEPTH; i++) nb_used[i] = 1'b0;
      nb_count = 0; sender_idx = 0; sender_valid = 0; pair_taken = 0;
   endfunction

   // Advance the predicted state by one accepted item and queue its results.
   function automatic void predict_node(cmd_type cmd, logic [63:0] h, logic [63:0] l,
                                        logic signed [63:0] num);
      int s;
      int last_idx;
      logic signed [127:0] acc, divisor, wide_num;
      case (cmd)
         CMD_UP: begin
            s = find_neighbor(h, l);
            if (s < 0) s = add_neighbor(h, l, '0);
            expect_result(KIND_STATUS, '0, '0, '0, '0, s >= 0 ? STS_OK : STS_FULL, 1'b1);
         end
         CMD_DOWN: begin
            s = find_neighbor(h, l);
            if (s >= 0) begin
               nb_used[s] = 1'b0; nb_count--;
               if (sender_valid && sender_idx == s) begin
                  sender_valid = 0; pair_taken = 0;
               end
            end
            expect_result(KIND_STATUS, '0, '0, '0, '0, s >= 0 ? STS_OK : STS_NOT_FOUND,
                          1'b1);
         end
         CMD_HDR: begin
            s = find_neighbor(h, l);
            if (s < 0) s = add_neighbor(h, l, num);
            pair_taken = 0;
            if (s >= 0) begin
               nb_estimate[s] = num; sender_idx = s; sender_valid = 1;
            end else sender_valid = 0;
            expect_result(KIND_STATUS, '0, '0, '0, '0, s >= 0 ? STS_OK : STS_FULL, 1'b1);
         end
         CMD_PAIR: begin
            if (sender_valid && !pair_taken && nb_used[sender_idx] &&
                h == self_id_high && l == self_id_low) begin
               wide_num = num;
               nb_flow[sender_idx] = saturate_q(-wide_num);
               pair_taken = 1;
            end
         end
         CMD_TICK: begin
            acc = local_val;
            last_idx = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!nb_used[i]) continue;
               wide_num = nb_flow[i]; acc = acc - wide_num;
               wide_num = nb_estimate[i]; acc = acc + wide_num;
               last_idx = i;
            end
            divisor = nb_count + 1;
            own_est = saturate_q(acc / divisor);   // truncates toward zero
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (!nb_used[i]) continue;
               acc = nb_flow[i]; wide_num = own_est; acc = acc + wide_num;
               wide_num = nb_estimate[i]; acc = acc - wide_num;
               nb_flow[i] = saturate_q(acc);
               nb_estimate[i] = own_est;
            end
            expect_result(KIND_EST, '0, '0, own_est, '0, STS_OK, last_idx < 0);
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (nb_used[i])
                  expect_result(KIND_FLOW, nb_id_high[i], nb_id_low[i], nb_flow[i], '0,
                                STS_OK, i == last_idx);
         end
         CMD_SET: local_val = num;
         CMD_READ: expect_result(KIND_READ, '0, '0, local_val, own_est, STS_OK, 1'b1);
         default: empty_table();
      endcase
   endfunction

   // Result checker: compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      node_result_t exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result kind=%0d first=%h", rsp_kind, rsp_first_number);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_kind !== exp_r.kind || rsp_peer_id_high !== exp_r.peer_high ||
                rsp_peer_id_low !== exp_r.peer_low || rsp_first_number !== exp_r.first_num ||
                rsp_second_number !== exp_r.second_num || rsp_status !== exp_r.status ||
                rsp_last !== exp_r.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp kind=%0d id=%h_%h n1=%h n2=%h st=%0d last=%0b",
                           exp_r.kind, exp_r.peer_high, exp_r.peer_low, exp_r.first_num,
                           exp_r.second_num, exp_r.status, exp_r.last,
                           " | got kind=%0d id=%h_%h n1=%h n2=%h st=%0d last=%0b",
                           rsp_kind, rsp_peer_id_high, rsp_peer_id_low, rsp_first_number,
                           rsp_second_number, rsp_status, rsp_last);
            end
         end
      end
   end

   // Receiver back-pressure: stall about 30% of cycles unless idling is switched off.
   always @(negedge clock)
      rsp_stall <= allow_idle && ($urandom_range(99) < 30);

   // Send one item; entered and left at a falling edge.
   task automatic send_item(cmd_type cmd, logic [63:0] h, logic [63:0] l, logic [63:0] num);
      if (allow_idle && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 30);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_node_id_high <= h;
      req_node_id_low <= l;
      req_number_in <= num;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_node(cmd, h, l, num);
      @(negedge clock);
   endtask

   // Drop valid, wait for every expected result, then let the block settle.
   task automatic drain_node();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [3:0] addr, logic [63:0] value);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_ID_HIGH) self_id_high = value;
      else self_id_low = value;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_number();
      int pick;
      pick = $urandom_range(99);
      if (pick < 6) return 64'h7FFF_FFFF_FFFF_FFFF;
      if (pick < 12) return 64'h8000_0000_0000_0000;
      if (pick < 16) return '0;
      if (pick < 50) return rand64();
      // small values near the typical working range
      return {{28{1'($urandom_range(1))}}, 4'($urandom), $urandom};
   endfunction

   function automatic logic [63:0] pool_id_low(int i);
      return id_pool[i] ^ 64'h5A5A_0000_0000_A5A5;
   endfunction

   task automatic test_registers();
      write_reg(ADDR_ID_HIGH, '1);
      write_reg(ADDR_ID_LOW, '1);
   endtask

   // Table handling, pairs, ticks and saturation with hand-picked items.
   task automatic test_table_directed();
      send_item(CMD_UP, '0, '0, '0);
      send_item(CMD_UP, '1, '1, '0);
      send_item(CMD_UP, '1, '1, '0);                    // duplicate stays ok
      send_item(CMD_DOWN, 64'h1234, 64'h5678, '0);       // not found
      send_item(CMD_HDR, 64'hAAAA, 64'h5555, 64'h7FFF_FFFF_FFFF_FFFF);
      send_item(CMD_PAIR, '1, '1, 64'h8000_0000_0000_0000);   // negate saturates
      send_item(CMD_PAIR, '1, '1, 64'h1);                // second pair is ignored
      send_item(CMD_SET, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_READ, '0, '0, '0);
      send_item(CMD_HDR, '0, '0, 64'h8000_0000_0000_0000);
      send_item(CMD_PAIR, '0, '1, 64'h5);                // wrong id, ignored
      send_item(CMD_DOWN, '0, '0, '0);                   // drop current sender
      send_item(CMD_PAIR, '1, '1, 64'h5);                // no sender, ignored
      for (int i = 0; i < 15; i++) send_item(CMD_UP, id_pool[i], pool_id_low(i), '0);
      send_item(CMD_UP, 64'hDEAD, 64'hBEEF, '0);         // table full
      send_item(CMD_HDR, 64'hDEAD, 64'hBEEF, 64'h10);    // full on header
      send_item(CMD_SET, '0, '0, 64'h8000_0000_0000_0000);
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_CLEAR, '1, '1, '1);
      send_item(CMD_TICK, '0, '0, '0);                   // empty table, estimate marked last
      send_item(CMD_READ, '1, '1, '1);
      drain_node();
   endtask

   // Header followed by pairs, mixed with table churn, ticks and noise items.
   task automatic test_random_traffic(int n_items);
      int count;
      int pick, p;
      logic [63:0] h, l;
      count = 0;
      while (count < n_items) begin
         if (count == n_items / 3) allow_idle = 1'b0;   // burst with no idling
         if (count == n_items / 2) allow_idle = 1'b1;
         pick = $urandom_range(99);
         p = $urandom_range(23);
         h = ($urandom_range(9) < 8) ? id_pool[p] : rand64();
         l = (h == id_pool[p]) ? pool_id_low(p) : rand64();
         if (pick < 38) begin
            send_item(CMD_HDR, h, l, rand_number());
            if ($urandom_range(9) < 8) send_item(CMD_PAIR, self_id_high, self_id_low,
                                                  rand_number());
            else send_item(CMD_PAIR, rand64(), rand64(), rand_number());
            count += 2;
            if ($urandom_range(9) < 2) begin
               send_item(CMD_PAIR, self_id_high, self_id_low, rand_number());
               count++;
            end
         end else if (pick < 54) begin
            send_item(CMD_UP, h, l, rand64()); count++;
         end else if (pick < 64) begin
            send_item(CMD_DOWN, h, l, rand64()); count++;
         end else if (pick < 78) begin
            send_item(CMD_TICK, rand64(), rand64(), rand64()); count++;
         end else if (pick < 85) begin
            send_item(CMD_SET, rand64(), rand64(), rand_number()); count++;
         end else if (pick < 92) begin
            send_item(CMD_READ, rand64(), rand64(), rand64()); count++;
         end else if (pick < 95) begin
            send_item(CMD_CLEAR, rand64(), rand64(), rand64()); count++;
         end else begin
            send_item(cmd_type'($urandom_range(7)), rand64(), rand64(), rand64());
            count++;
         end
      end
      drain_node();
   endtask

   initial begin
      empty_table();
      local_val = '0; own_est = '0; self_id_high = '0; self_id_low = '0;
      for (int i = 0; i < 24; i++) id_pool[i] = rand64();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_registers();
      test_table_directed();
      write_reg(ADDR_ID_HIGH, '0);
      write_reg(ADDR_ID_LOW, '0);
      test_random_traffic(66);
      write_reg(ADDR_ID_HIGH, rand64());
      write_reg(ADDR_ID_LOW, rand64());
      test_random_traffic(66);
      write_reg(ADDR_ID_HIGH, 64'h8000_0000_0000_0001);
      write_reg(ADDR_ID_LOW, 64'h7FFF_FFFF_FFFF_FFFE);
      test_random_traffic(60);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/fua_pkg.sv
hw/rtl/fua_ram.sv
hw/rtl/fua_div.sv
hw/rtl/flow_updating_average_node.sv
verif/flow_updating_average_node_tb.sv
